// ===== design/assert_macros.svh =====
// Assertion macros shared by the page table walker modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

// ===== design/svptw_pkg.sv =====
// Types and constants of the Sv39 page table walker.
// Depends on nothing; imported by every module of the walker.
package svptw_pkg;

  localparam int unsigned PpnW   = 44;
  localparam int unsigned AddrW  = 56;
  localparam int unsigned VaW    = 39;
  localparam int unsigned VaLimW = 38;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned OffW   = 12;
  localparam int unsigned LvlW   = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 44;
  localparam int unsigned QDepth = 2;

  localparam logic OpTranslate = 1'b0;
  localparam logic OpPte       = 1'b1;
  localparam logic KindRead    = 1'b0;
  localparam logic KindDone    = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgRootPpn  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgUserMode = 1'b1;

  localparam int unsigned PteVBit   = 0;
  localparam int unsigned PteUBit   = 4;
  localparam int unsigned PtePpnLsb = 10;

  typedef struct packed {
    logic        op;
    logic [63:0] vaddr;
    logic [63:0] pte_data;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] mem_addr;
    logic [AddrW-1:0] phys_addr;
    logic             fault;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_RANGE_FAULT,
    CMD_PTE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [VaW-1:0]   vaddr;
    logic [PpnW-1:0]  ppn;
    logic             pte_v;
    logic             pte_u;
  } cmd_t;

endpackage

// ===== design/svptw_front.sv =====
// Front part of the walker: takes input transfers and classifies them.
// Depends on svptw_pkg; feeds the command queue.
module svptw_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  svptw_pkg::in_item_t in_item_i,
  output logic                push_o,
  input  logic                full_i,
  output svptw_pkg::cmd_t     cmd_o
);
  import svptw_pkg::*;

  logic out_of_range;

  assign out_of_range = |in_item_i.vaddr[63:VaLimW];
  assign in_stall_o   = full_i;
  assign push_o       = in_valid_i && !full_i;

  always_comb begin
    cmd_o       = '0;
    cmd_o.vaddr = in_item_i.vaddr[VaW-1:0];
    cmd_o.ppn   = in_item_i.pte_data[PtePpnLsb +: PpnW];
    cmd_o.pte_v = in_item_i.pte_data[PteVBit];
    cmd_o.pte_u = in_item_i.pte_data[PteUBit];
    if (in_item_i.op == OpPte) begin
      cmd_o.kind = CMD_PTE;
    end else if (out_of_range) begin
      cmd_o.kind = CMD_RANGE_FAULT;
    end else begin
      cmd_o.kind = CMD_START;
    end
  end

endmodule

// ===== design/svptw_queue.sv =====
// Short command queue between the front and back parts of the walker.
// Depends on svptw_pkg and assert_macros.svh.
`include "assert_macros.svh"
module svptw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  svptw_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output svptw_pkg::cmd_t data_o
);
  import svptw_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QDepth);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_CLK(a_count_bounded, clk_i, rst_ni, count_q <= FullCnt)
  `ASSERT_CLK(a_pop_not_empty, clk_i, rst_ni, pop_i |-> count_q != '0)
  `ASSERT_CLK(a_push_not_full, clk_i, rst_ni, (push_i && !pop_i) |-> !full_o)

endmodule

// ===== design/svptw_back.sv =====
// Back part of the walker: walk state, configuration registers and result register.
// Depends on svptw_pkg and assert_macros.svh; consumes the command queue.
`include "assert_macros.svh"
module svptw_back #(
  parameter int unsigned LEVELS = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [svptw_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [svptw_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                q_valid_i,
  input  svptw_pkg::cmd_t                     q_data_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output svptw_pkg::out_item_t                out_item_o
);
  import svptw_pkg::*;

  localparam logic [LvlW-1:0] TopLevel = LvlW'(LEVELS - 1);

  logic            busy_q, busy_d;
  logic [LvlW-1:0] level_q, level_d;
  logic [VaW-1:0]  vaddr_q, vaddr_d;
  logic [PpnW-1:0] table_ppn_q, table_ppn_d;
  logic [PpnW-1:0] root_ppn_q;
  logic            user_mode_q;
  logic            out_valid_q;
  out_item_t       out_item_q;
  logic            res_valid;
  out_item_t       res;
  logic [IdxW-1:0] idx;

  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    case (level_d)
      2'd0:    idx = vaddr_d[OffW +: IdxW];
      2'd1:    idx = vaddr_d[OffW + IdxW +: IdxW];
      2'd2:    idx = vaddr_d[OffW + 2 * IdxW +: IdxW];
      default: idx = '0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    level_d     = level_q;
    vaddr_d     = vaddr_q;
    table_ppn_d = table_ppn_q;
    res_valid   = 1'b0;
    res         = '0;
    res.kind    = KindDone;
    case (q_data_i.kind)
      CMD_RANGE_FAULT: begin
        busy_d    = 1'b0;
        res_valid = 1'b1;
        res.fault = 1'b1;
      end
      CMD_START: begin
        busy_d      = 1'b1;
        level_d     = TopLevel;
        vaddr_d     = q_data_i.vaddr;
        table_ppn_d = root_ppn_q;
        res_valid   = 1'b1;
        res.kind    = KindRead;
      end
      CMD_PTE: begin
        if (busy_q) begin
          res_valid = 1'b1;
          if (!q_data_i.pte_v) begin
            busy_d    = 1'b0;
            res.fault = 1'b1;
          end else if (level_q != '0) begin
            table_ppn_d = q_data_i.ppn;
            level_d     = level_q - 1'b1;
            res.kind    = KindRead;
          end else begin
            busy_d = 1'b0;
            if (user_mode_q) begin
              if (!q_data_i.pte_u) begin
                res.fault = 1'b1;
              end else begin
                res.phys_addr = {q_data_i.ppn, {OffW{1'b0}}};
              end
            end else begin
              res.phys_addr = {q_data_i.ppn, vaddr_q[OffW-1:0]};
            end
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    if (res.kind == KindRead) begin
      res.mem_addr = {table_ppn_d, idx, 3'b000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      level_q     <= '0;
      vaddr_q     <= '0;
      table_ppn_q <= '0;
      root_ppn_q  <= '0;
      user_mode_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRootPpn:  root_ppn_q  <= cfg_data_i;
          CfgUserMode: user_mode_q <= cfg_data_i[0];
          default:     root_ppn_q  <= root_ppn_q;
        endcase
      end
      if (q_pop_o) begin
        busy_q      <= busy_d;
        level_q     <= level_d;
        vaddr_q     <= vaddr_d;
        table_ppn_q <= table_ppn_d;
        out_valid_q <= res_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && res_valid) begin
      out_item_q <= res;
    end
  end

  `ASSERT_CLK(a_read_leaves_busy, clk_i, rst_ni,
              (q_pop_o && res_valid && res.kind == KindRead) |=> busy_q)
  `ASSERT_CLK(a_fault_no_addr, clk_i, rst_ni,
              (out_valid_q && out_item_q.fault) |-> out_item_q.phys_addr == '0)
  `ASSERT_CLK(a_idle_level_top, clk_i, rst_ni,
              (q_pop_o && q_data_i.kind == CMD_START) |=> level_q == TopLevel)

endmodule

// ===== design/sv39_page_table_walker_top.sv =====
// Sv39 page table walker: a front classifier, a two-entry command queue and
// a back part that holds the walk state. One transfer is accepted per clock
// cycle when the queue has room, and one result transfer leaves per cycle
// while the output is not stalled; a result passes the queue register, then
// the output register. A translate request yields a PTE read request, or a
// fault if out of range; each PTE response yields the next read or the
// finished translation, and a response with no walk in progress yields
// nothing. Configuration writes must happen while no walk is pending.
module sv39_page_table_walker_top #(
  parameter int unsigned LEVELS = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [svptw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [svptw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  svptw_pkg::in_item_t            in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output svptw_pkg::out_item_t           out_item_o
);
  import svptw_pkg::*;

  logic push;
  logic full;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  svptw_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .full_i     (full),
    .cmd_o      (push_cmd)
  );

  svptw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  svptw_back #(
    .LEVELS (LEVELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_data_i    (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== verif/tb_sv39_page_table_walker_top.sv =====
// Self-checking testbench for the Sv39 page table walker top level.
// Depends on svptw_pkg and sv39_page_table_walker_top; a tracker class
// predicts each walk step, and plain tasks drive transfers and config writes.
`timescale 1ns / 1ps

module tb_sv39_page_table_walker_top;
  import svptw_pkg::*;

  localparam int unsigned WalkLevels = 3;
  localparam int unsigned PhaseItems = 290;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 80;

  class walk_tracker;
    out_item_t expected_results[$];
    logic [PpnW-1:0] root_ppn;
    logic user_mode;
    logic walking;
    logic [LvlW-1:0] level;
    logic [VaW-1:0] walk_va;
    logic [PpnW-1:0] table_ppn;
    int mismatches;

    function new();
      root_ppn = '0;
      user_mode = 1'b1;
      walking = 1'b0;
      level = '0;
      walk_va = '0;
      table_ppn = '0;
      mismatches = 0;
    endfunction

    function void set_walk_config(logic [PpnW-1:0] root, logic user);
      root_ppn = root;
      user_mode = user;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void push_pte_read();
      out_item_t r;
      logic [IdxW-1:0] idx;
      idx = walk_va[OffW + IdxW * level +: IdxW];
      r.kind = KindRead;
      r.mem_addr = {table_ppn, idx, 3'b000};
      r.phys_addr = '0;
      r.fault = 1'b0;
      expected_results.push_back(r);
    endfunction

    function void push_finished(logic [AddrW-1:0] pa, logic flt);
      out_item_t r;
      r.kind = KindDone;
      r.mem_addr = '0;
      r.phys_addr = flt ? '0 : pa;
      r.fault = flt;
      expected_results.push_back(r);
    endfunction

    // Returns 1 when the accepted transfer leads to a result.
    function bit predict_walk_step(in_item_t it);
      logic [PpnW-1:0] ppn;
      ppn = it.pte_data[PtePpnLsb +: PpnW];
      if (it.op == OpTranslate) begin
        walking = 1'b0;
        if (it.vaddr[63:VaLimW] != '0) begin
          push_finished('0, 1'b1);
          return 1'b1;
        end
        walking = 1'b1;
        level = LvlW'(WalkLevels - 1);
        walk_va = it.vaddr[VaW-1:0];
        table_ppn = root_ppn;
        push_pte_read();
        return 1'b1;
      end
      if (!walking) return 1'b0;
      if (!it.pte_data[PteVBit]) begin
        walking = 1'b0;
        push_finished('0, 1'b1);
      end else if (level != '0) begin
        table_ppn = ppn;
        level = level - 1'b1;
        push_pte_read();
      end else begin
        walking = 1'b0;
        if (user_mode && !it.pte_data[PteUBit]) begin
          push_finished('0, 1'b1);
        end else if (user_mode) begin
          push_finished({ppn, 12'h000}, 1'b0);
        end else begin
          push_finished({ppn, walk_va[OffW-1:0]}, 1'b0);
        end
      end
      return 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind) begin
        mismatches++;
        $display("%0t: kind expected %h actual %h", $time, want.kind, got.kind);
      end
      if (got.mem_addr !== want.mem_addr) begin
        mismatches++;
        $display("%0t: mem_addr expected %h actual %h", $time, want.mem_addr, got.mem_addr);
      end
      if (got.phys_addr !== want.phys_addr) begin
        mismatches++;
        $display("%0t: phys_addr expected %h actual %h", $time, want.phys_addr,
                 got.phys_addr);
      end
      if (got.fault !== want.fault) begin
        mismatches++;
        $display("%0t: fault expected %h actual %h", $time, want.fault, got.fault);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  in_item_t in_item = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_item_t out_item;

  walk_tracker tracker = new();
  int unsigned send_gap_pct = 20;
  int unsigned recv_gap_pct = 20;
  bit hold_req = 1'b0;
  int results_due = 0;
  int unsigned quiet_cycles = 0;

  sv39_page_table_walker_top #(
    .LEVELS(WalkLevels)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_item_i(in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_item);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if ($urandom_range(99) < recv_gap_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(13, 1)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_va();
    logic [63:0] v;
    v = rand64();
    v[63:VaLimW] = '0;
    return v;
  endfunction

  function automatic in_item_t make_request(logic [63:0] va);
    in_item_t it;
    it.op = OpTranslate;
    it.vaddr = va;
    it.pte_data = rand64();
    return it;
  endfunction

  function automatic in_item_t make_pte(logic [63:0] pte);
    in_item_t it;
    it.op = OpPte;
    it.vaddr = rand64();
    it.pte_data = pte;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (tracker.predict_walk_step(it)) results_due++;
    @(negedge clk);
  endtask

  task automatic apply_config(logic [PpnW-1:0] root, logic user);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CfgRootPpn;
    cfg_data <= root;
    @(negedge clk);
    cfg_idx <= CfgUserMode;
    cfg_data <= {{(CfgDataW-1){1'b0}}, user};
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_walk_config(root, user);
  endtask

  task automatic run_directed();
    send_item(make_pte('1));
    send_item(make_request('0));
    repeat (3) send_item(make_pte('1));
    send_item(make_request((64'd1 << VaLimW) - 1));
    repeat (3) send_item(make_pte(64'd1));
    send_item(make_request(64'd1 << VaLimW));
    send_item(make_request('1));
    send_item(make_request(rand_va()));
    send_item(make_pte('0));
    send_item(make_request(rand_va()));
    send_item(make_pte(rand64() | 64'd1));
    send_item(make_request(rand_va()));
    send_item(make_pte(rand64() | 64'd1));
    send_item(make_pte(64'hFFFF_FFFF_FFFF_FFFE));
    send_item(make_request(rand_va()));
    repeat (2) send_item(make_pte(rand64() | 64'd1));
    send_item(make_pte(rand64() | 64'h11));
  endtask

  task automatic send_range_fault();
    logic [63:0] v;
    v = rand64();
    if (v[63:VaLimW] == '0) v[VaLimW + $urandom_range(63 - VaLimW)] = 1'b1;
    send_item(make_request(v));
  endtask

  task automatic drive_walk_mix(int target, bit calm);
    int start;
    int unsigned pick;
    logic [63:0] pte;
    start = results_due;
    while (results_due - start < target) begin
      if (!calm && $urandom_range(39) == 0) begin
        send_gap_pct = $urandom_range(3) * 15;
        recv_gap_pct = $urandom_range(3) * 15;
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_item(make_request(rand_va()));
        for (int lvl = WalkLevels - 1; lvl >= 0; lvl--) begin
          pte = rand64();
          pte[PteVBit] = ($urandom_range(19) != 0);
          if (lvl == 0) pte[PteUBit] = ($urandom_range(6) != 0);
          send_item(make_pte(pte));
          if (!pte[PteVBit]) break;
        end
      end else if (pick < 83) begin
        send_range_fault();
      end else if (pick < 91) begin
        send_item(make_request(rand_va()));
        repeat ($urandom_range(2)) send_item(make_pte(rand64() | 64'd1));
      end else begin
        send_item(make_pte(rand64()));
      end
    end
    send_range_fault();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    apply_config('0, 1'b1);
    run_directed();
    apply_config('1, 1'b0);
    hold_req = 1'b1;
    drive_walk_mix(PhaseItems, 1'b0);
    apply_config(PpnW'(rand64()), 1'b1);
    drive_walk_mix(PhaseItems, 1'b0);
    apply_config(PpnW'(rand64()), 1'b0);
    drive_walk_mix(PhaseItems, 1'b0);
    apply_config('1, 1'b1);
    drive_walk_mix(PhaseItems, 1'b0);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    apply_config('0, 1'b0);
    drive_walk_mix(PhaseItems, 1'b1);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/svptw_pkg.sv
design/svptw_front.sv
design/svptw_queue.sv
design/svptw_back.sv
design/sv39_page_table_walker_top.sv
verif/tb_sv39_page_table_walker_top.sv
